### sv/wfws_pkg.sv
// Package for the waypoint follower wheel speed block.
// Holds the item structs, command codes, fixed-point constants and the arctangent table.
// Depends on nothing; the top level uses it by scoped names.
package wfws_pkg;

  localparam int MaxPoints   = 1024;
  localparam int PtrW        = $clog2(MaxPoints) + 1;
  localparam int AddrW       = $clog2(MaxPoints);
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int CordicW     = 28;
  localparam int RotCoef     = 12868;
  localparam int RotLimit    = 512;
  localparam int WpW         = 48;

  localparam logic [2:0] CmdClear   = 3'd0;
  localparam logic [2:0] CmdAppend  = 3'd1;
  localparam logic [2:0] CmdStart   = 3'd2;
  localparam logic [2:0] CmdStop    = 3'd3;
  localparam logic [2:0] CmdProceed = 3'd4;
  localparam logic [2:0] CmdPose    = 3'd5;

  localparam logic RegPosTolerance = 1'b0;
  localparam logic RegMaxSpeed     = 1'b1;

  localparam logic [14:0] PosToleranceReset = 15'd102;
  localparam logic [14:0] MaxSpeedReset     = 15'd1024;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] waypoint_x;
    logic signed [15:0] waypoint_y;
    logic signed [15:0] waypoint_speed;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
    logic signed [15:0] robot_heading;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               running;
    logic               list_done;
    logic               status;
  } out_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/wfws_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module wfws_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/waypoint_follower_wheel_speeds_core.sv
// Top level of the waypoint follower: command sequencer, shared multiplier and CORDIC unit.
// Depends on wfws_pkg and wfws_ram.
//
// The in_ channel takes one command item when in_valid is high and in_stall low. Clear,
// append, start, stop, proceed and unused commands, and a pose item at the list's end,
// answer directly: the result item is registered at the accept edge and shows on out_
// the next cycle. A pose item that finds its waypoint reached answers from the distance
// compare; one that steers answers after the 16 iterations of the shared CORDIC shifter
// and adder and the sequential use of one 17 by 17 multiplier for distance and rotation.
// The waypoint store is one RAM of 1024 entries with a registered read.
// Exactly one result item follows every input item. While a pose item is at work the
// block holds in_stall high. A waiting result in the output register stays stable while
// out_stall is high, and the next item is taken only once that result leaves or is
// leaving. Reset clears the list, the pointer, the run flag, the wishes and restores the
// tolerance and speed limit registers; the store itself needs no clearing since only
// entries below the fill count are read. Configuration is written through the cfg_ port.
module waypoint_follower_wheel_speeds_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  wfws_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output wfws_pkg::out_t   out_data,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIFF, S_SQX, S_SQY, S_SQT, S_CMP, S_CIT, S_ERR, S_ROT, S_LIM, S_OUT
  } state_t;

  localparam int CW = wfws_pkg::CordicW;
  localparam int PW = wfws_pkg::PtrW;
  localparam int StepWm1 = wfws_pkg::StepW - 1;

  state_t state_r, state_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic run_r, run_nxt;
  logic signed [15:0] lw_r, lw_nxt, rw_r, rw_nxt;
  logic [14:0] tol_r, ms_r;
  logic out_valid_r, out_valid_nxt;
  wfws_pkg::out_t out_r, out_nxt;
  logic signed [15:0] rx_r, rx_nxt, ry_r, ry_nxt, hd_r, hd_nxt;
  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [33:0] acc_r, acc_nxt;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0] cz_r, cz_nxt;
  logic [StepWm1:0] it_r, it_nxt;
  logic neg_r, neg_nxt;
  logic signed [10:0] rot_r, rot_nxt;
  logic signed [17:0] tra_r, tra_nxt;

  logic [wfws_pkg::WpW-1:0] rd_data;
  logic we;
  logic in_acc, cfg_wr;

  logic signed [15:0] wp_x, wp_y, wp_v;
  logic signed [CW-1:0] xs, ys, x0, y0;
  logic [15:0] bearing, err16, err_abs;
  logic [33:0] magw;
  logic [18:0] mag;
  logic signed [17:0] s_tra, s_rot, s_ms, s_sum, s_dif;

  assign wp_x = $signed(rd_data[47:32]);
  assign wp_y = $signed(rd_data[31:16]);
  assign wp_v = $signed(rd_data[15:0]);

  wfws_ram #(
    .WIDTH(wfws_pkg::WpW),
    .DEPTH(wfws_pkg::MaxPoints)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cnt_r[wfws_pkg::AddrW-1:0]),
    .wdata({in_data.waypoint_x, in_data.waypoint_y, in_data.waypoint_speed}),
    .raddr(ptr_r[wfws_pkg::AddrW-1:0]),
    .rdata(rd_data)
  );

  assign in_stall   = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == wfws_pkg::RegMaxSpeed) ? {17'd0, ms_r} : {17'd0, tol_r};

  assign prod_nxt = mul_a * mul_b;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign x0 = CW'(dx_r) <<< 8;
  assign y0 = CW'(dy_r) <<< 8;
  assign bearing = 16'((cz_r + 32'h8000) >> 16);
  assign err16 = bearing - hd_r;
  assign err_abs = (err16[15] && err16 != 16'h8000) ? 16'(-err16) : err16;
  assign magw = 34'(prod_r) + 34'd32768;
  assign mag = {1'b0, magw[33:16]};
  assign s_tra = tra_r;
  assign s_rot = 18'(rot_r);
  assign s_ms  = $signed({3'd0, ms_r});
  assign s_sum = s_tra + s_rot;
  assign s_dif = s_tra - s_rot;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    logic load;
    logic st;
    logic [PW-1:0] pinc;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    run_nxt = run_r;
    lw_nxt = lw_r;
    rw_nxt = rw_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    hd_nxt = hd_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    acc_nxt = acc_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    it_nxt = it_r;
    neg_nxt = neg_r;
    rot_nxt = rot_r;
    tra_nxt = tra_r;
    mul_a = dx_r;
    mul_b = dx_r;
    we = 1'b0;
    load = 1'b0;
    st = 1'b0;
    pinc = ptr_r + PW'(1);
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          load = 1'b1;
          case (in_data.command)
            wfws_pkg::CmdClear: begin
              cnt_nxt = '0;
              ptr_nxt = '0;
            end
            wfws_pkg::CmdAppend: begin
              if (cnt_r < PW'(wfws_pkg::MaxPoints)) begin
                we = 1'b1;
                cnt_nxt = cnt_r + PW'(1);
              end else begin
                st = 1'b1;
              end
            end
            wfws_pkg::CmdStart: begin
              ptr_nxt = '0;
              run_nxt = 1'b1;
            end
            wfws_pkg::CmdStop: run_nxt = 1'b0;
            wfws_pkg::CmdProceed: run_nxt = 1'b1;
            wfws_pkg::CmdPose: begin
              rx_nxt = in_data.robot_x;
              ry_nxt = in_data.robot_y;
              hd_nxt = in_data.robot_heading;
              if (ptr_r < cnt_r) begin
                load = 1'b0;
                state_nxt = S_RD;
              end else begin
                lw_nxt = '0;
                rw_nxt = '0;
                run_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: state_nxt = S_DIFF;
      S_DIFF: begin
        dx_nxt = 17'(wp_x) - 17'(rx_r);
        dy_nxt = 17'(wp_y) - 17'(ry_r);
        state_nxt = S_SQX;
      end
      S_SQX: state_nxt = S_SQY;
      S_SQY: begin
        acc_nxt = prod_r;
        mul_a = dy_r;
        mul_b = dy_r;
        state_nxt = S_SQT;
      end
      S_SQT: begin
        acc_nxt = acc_r + prod_r;
        mul_a = $signed({2'd0, tol_r});
        mul_b = $signed({2'd0, tol_r});
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (acc_r > 34'(prod_r)) begin
          if (dx_r < 0) begin
            cx_nxt = -x0;
            cy_nxt = -y0;
            cz_nxt = 32'h8000_0000;
          end else begin
            cx_nxt = x0;
            cy_nxt = y0;
            cz_nxt = '0;
          end
          it_nxt = '0;
          state_nxt = S_CIT;
        end else begin
          ptr_nxt = pinc;
          if (pinc >= cnt_r) begin
            lw_nxt = '0;
            rw_nxt = '0;
            run_nxt = 1'b0;
          end
          load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CIT: begin
        if (cy_r >= 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + wfws_pkg::atan_lut(5'(it_r));
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - wfws_pkg::atan_lut(5'(it_r));
        end
        it_nxt = it_r + 1'b1;
        if (it_r == wfws_pkg::StepW'(wfws_pkg::CordicSteps - 1)) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        neg_nxt = err16[15] && err16 != 16'h8000;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (mag > 19'(wfws_pkg::RotLimit)) begin
          rot_nxt = neg_r ? -11'sd512 : 11'sd512;
        end else begin
          rot_nxt = neg_r ? -$signed(11'(mag)) : $signed(11'(mag));
        end
        tra_nxt = 18'(wp_v);
        state_nxt = S_LIM;
      end
      S_LIM: begin
        if ((s_tra > 0 && s_rot > 0) || (s_tra < 0 && s_rot < 0)) begin
          if (s_sum > s_ms) tra_nxt = s_ms - s_rot;
          if (s_sum < -s_ms) tra_nxt = -s_ms - s_rot;
        end else if ((s_tra > 0 && s_rot < 0) || (s_tra < 0 && s_rot > 0)) begin
          if (s_dif > s_ms) tra_nxt = s_ms + s_rot;
          if (s_dif < -s_ms) tra_nxt = -s_ms + s_rot;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        lw_nxt = sat16(s_sum);
        rw_nxt = sat16(s_dif);
        load = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_ERR) begin
      mul_a = $signed({1'b0, err_abs});
      mul_b = 17'(wfws_pkg::RotCoef);
    end
    out_nxt = out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt.left_speed = lw_nxt;
      out_nxt.right_speed = rw_nxt;
      out_nxt.running = run_nxt;
      out_nxt.list_done = ptr_nxt >= cnt_nxt;
      out_nxt.status = st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ptr_r <= '0;
      run_r <= 1'b0;
      lw_r <= '0;
      rw_r <= '0;
      out_valid_r <= 1'b0;
      tol_r <= wfws_pkg::PosToleranceReset;
      ms_r <= wfws_pkg::MaxSpeedReset;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
      run_r <= run_nxt;
      lw_r <= lw_nxt;
      rw_r <= rw_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == wfws_pkg::RegPosTolerance) tol_r <= cfg_pwdata[14:0];
      if (cfg_wr && cfg_paddr[2] == wfws_pkg::RegMaxSpeed) ms_r <= cfg_pwdata[14:0];
    end
    out_r <= out_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    hd_r <= hd_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    cz_r <= cz_nxt;
    it_r <= it_nxt;
    neg_r <= neg_nxt;
    rot_r <= rot_nxt;
    tra_r <= tra_nxt;
  end

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("item taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PW'(wfws_pkg::MaxPoints)) else $error("fill count beyond store depth");
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> !out_valid_r) else $error("result pending during pose work");
  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIM |-> (rot_r <= 11'sd512 && rot_r >= -11'sd512))
    else $error("rotation share out of range");
`endif

endmodule
